@@ rtl/mpq_pkg.sv @@
// shared types and constants for the min priority queue
// operation and status codes, cell control and slot structs; no dependencies
`default_nettype none

package mpq_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned ENTRIES_W = 7;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_PEEK    = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_cmd_e;

  // broadcast to every cell
  typedef struct packed {
    cell_cmd_e               cmd;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

  // contents of one cell, as seen by its neighbors
  typedef struct packed {
    logic                    vld;
    logic signed [KEY_W-1:0] key;
  } slot_t;

endpackage

`default_nettype wire

@@ rtl/mpq_if.sv @@
// request and response channels of the min priority queue
// valid/ready handshake with payload; depends on mpq_pkg
`default_nettype none

interface mpq_req_if;
  logic                          valid;
  logic                          ready;
  logic [mpq_pkg::OP_W-1:0]      op;
  logic signed [mpq_pkg::KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface mpq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [mpq_pkg::KEY_W-1:0] taken_key;
  logic [mpq_pkg::STATUS_W-1:0]     status;
  logic signed [mpq_pkg::KEY_W-1:0] min_after;
  logic                             min_valid;
  logic [mpq_pkg::ENTRIES_W-1:0]    entries;

  modport source (output valid, output taken_key, output status, output min_after,
                  output min_valid, output entries, input ready);
  modport sink   (input valid, input taken_key, input status, input min_after,
                  input min_valid, input entries, output ready);
endinterface

`default_nettype wire

@@ rtl/mpq_cell.sv @@
// one cell of the sorted key chain
// holds one key and a valid bit, trades with its neighbors; depends on mpq_pkg
`default_nettype none

module mpq_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire mpq_pkg::cell_ctl_t  ctl_i,
  input  wire mpq_pkg::slot_t      left_i,
  input  wire                      left_lt_i,
  input  wire mpq_pkg::slot_t      right_i,
  output mpq_pkg::slot_t           slot_o,
  output logic                     lt_o
);
  import mpq_pkg::*;

  logic                    vld_q, vld_d;
  logic signed [KEY_W-1:0] key_q, key_d;

  // new key belongs at or before this cell; an empty cell counts as +inf
  assign lt_o = !vld_q || ($signed(ctl_i.key) < key_q);

  always_comb begin
    vld_d = vld_q;
    key_d = key_q;
    case (ctl_i.cmd)
      CELL_INSERT: begin
        if (lt_o) begin
          if (left_lt_i) begin
            vld_d = left_i.vld;
            key_d = left_i.key;
          end else begin
            vld_d = 1'b1;
            key_d = ctl_i.key;
          end
        end
      end
      CELL_SHIFT: begin
        vld_d = right_i.vld;
        key_d = right_i.key;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign slot_o.vld = vld_q;
  assign slot_o.key = key_q;

endmodule

`default_nettype wire

@@ rtl/min_priority_queue.sv @@
// Bounded min priority queue of signed 32-bit keys, kept as a sorted chain of
// CAPACITY cells with the smallest key always in cell 0. An insert drops into
// place, every cell comparing the broadcast key with its own and taking its
// left neighbor's key or the new one; an extract shifts the whole chain one
// cell toward the head; a peek only reads cell 0. The cells update at the
// edge that accepts a request beat; the response register then samples cell 0
// and the count once the output register is free, and no new request is
// accepted until it has. A finished response may sit in the output register
// while the next request is accepted. Reset clears the cell valid bits and
// the count at once; no clearing pass is needed. Op code three is a no-op
// that reports the unchanged queue with status ok.
// depends on mpq_pkg, mpq_if and mpq_cell
`default_nettype none

module min_priority_queue (
  input  wire        clk_i,
  input  wire        rst_ni,
  mpq_req_if.sink    req_i,
  mpq_rsp_if.source  rsp_o
);
  import mpq_pkg::*;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  // cell chain
  cell_ctl_t ctl;
  slot_t     slots [CAPACITY];
  logic      lts   [CAPACITY];

  // control
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     pend_q;
  logic signed [KEY_W-1:0]  taken_q, taken_d;
  status_e                  status_q, status_d;
  logic                     accept, empty, full, rsp_load;

  // response register
  logic                     rsp_vld_q;
  logic signed [KEY_W-1:0]  rsp_taken_q, rsp_min_q;
  status_e                  rsp_status_q;
  logic                     rsp_min_vld_q;
  logic [ENTRIES_W-1:0]     rsp_entries_q;

  assign req_i.ready = !pend_q;
  assign accept      = req_i.valid && req_i.ready;
  assign empty       = (count_q == '0);
  assign full        = (count_q == CNT_FULL);

  // decode one request beat into a chain command
  always_comb begin
    ctl.cmd  = CELL_HOLD;
    ctl.key  = req_i.key;
    count_d  = count_q;
    taken_d  = '0;
    status_d = ST_OK;
    case (req_i.op)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctl.cmd = CELL_INSERT;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_EXTRACT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctl.cmd = CELL_SHIFT;
          taken_d = slots[0].key;
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          taken_d = slots[0].key;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctl.cmd = CELL_HOLD;
      count_d = count_q;
    end
  end

  // the chain: cell 0 holds the minimum, empty cells trail at the tail
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left, right;
    logic  left_lt;

    if (i == 0) begin : g_head
      assign left    = '0;
      assign left_lt = 1'b0;
    end else begin : g_mid
      assign left    = slots[i-1];
      assign left_lt = lts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = slots[i+1];
    end

    mpq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .left_i    (left),
      .left_lt_i (left_lt),
      .right_i   (right),
      .slot_o    (slots[i]),
      .lt_o      (lts[i])
    );
  end

  // response is built from the settled chain once an operation is pending and the output register is free
  assign rsp_load = pend_q && (!rsp_vld_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      pend_q    <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        pend_q <= 1'b1;
      end else if (rsp_load) begin
        pend_q <= 1'b0;
      end
      if (rsp_load) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      taken_q  <= taken_d;
      status_q <= status_d;
    end
    if (rsp_load) begin
      rsp_taken_q   <= taken_q;
      rsp_status_q  <= status_q;
      rsp_min_vld_q <= slots[0].vld;
      rsp_min_q     <= slots[0].vld ? slots[0].key : '0;
      rsp_entries_q <= ENTRIES_W'(count_q);
    end
  end

  assign rsp_o.valid     = rsp_vld_q;
  assign rsp_o.taken_key = rsp_taken_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.min_after = rsp_min_q;
  assign rsp_o.min_valid = rsp_min_vld_q;
  assign rsp_o.entries   = rsp_entries_q;

`ifndef SYNTHESIS
  // head of the chain is occupied exactly when the count is nonzero
  a_head_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots[0].vld == (count_q != '0))
    else $error("head cell valid bit disagrees with entry count");

  // a successful extract lowers the count by one
  a_extract_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.op == OP_EXTRACT && !empty) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("extract did not decrement the entry count");

  // loading a response marks it valid and clears the pending operation
  a_rsp_from_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_load) |=> (rsp_vld_q && !pend_q))
    else $error("response load left state inconsistent");

  // the count never passes capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("entry count above capacity");
`endif

endmodule

`default_nettype wire
